// ----- hw/rtl/rtnh_pkg.sv -----
// shared types, widths and codes for the ray / triangle nearest-hit finder
`default_nettype none

package rtnh_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int MAX_SURFACES  = 16;
  localparam int MAX_TRIANGLES = 65536;

  localparam int SURF_W  = 4;
  localparam int TRI_W   = 16;
  localparam int EPS_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int DIST_W  = 31;
  localparam int CFG_W   = COORD_WIDTH;
  localparam int CFG_A_W = 3;

  // edge, multiplier operand, cross product and dot product widths
  localparam int EDGE_W = COORD_WIDTH + 1;
  localparam int OP_W   = COORD_WIDTH + 2;
  localparam int PROD_W = 2 * OP_W;
  localparam int LO_W   = OP_W - 1;
  localparam int WV_W   = 2 * EDGE_W + 1;
  localparam int DOT_W  = EDGE_W + WV_W + 1;
  localparam int H_W    = DOT_W - 1;

  localparam int DIV_SH0 = DIST_W - 1 - FRAC_W;
  localparam int SAT_SH  = DIST_W - FRAC_W;
  localparam int EPS_SH  = 2 * FRAC_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [CFG_A_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_A_W-1:0] REG_DET_EPS  = 3'd6;

  typedef enum logic [2:0] {
    G_PV,
    G_QV,
    G_DET,
    G_UN,
    G_VN,
    G_TN
  } grp_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_NORM,
    S_CHECK,
    S_DIV,
    S_DONE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic       hi;
    logic       sub;
    logic       first;
    logic       last;
    grp_e       grp;
    logic [1:0] comp;
  } mac_ctrl_t;

  typedef struct packed {
    logic       valid;
    grp_e       grp;
    logic [1:0] comp;
  } mac_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rtnh_mac.sv -----
// shared signed multiplier with registered product and wide accumulator
`default_nettype none

module rtnh_mac (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              issue_i,
  input  wire rtnh_pkg::mac_ctrl_t               ctrl_i,
  input  wire logic signed [rtnh_pkg::OP_W-1:0]  a_i,
  input  wire logic signed [rtnh_pkg::OP_W-1:0]  b_i,
  output rtnh_pkg::mac_wr_t                      wr_o,
  output logic signed [rtnh_pkg::DOT_W-1:0]      acc_o
);
  import rtnh_pkg::*;

  logic                     vld_q;
  mac_ctrl_t                ctrl_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DOT_W-1:0]  acc_q, acc_d, base, term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= a_i * b_i;
      ctrl_q <= ctrl_i;
    end
    if (vld_q) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    base = ctrl_q.first ? '0 : acc_q;
    term = DOT_W'(prod_q);
    if (ctrl_q.hi) begin
      term = term <<< LO_W;
    end
    acc_d = ctrl_q.sub ? base - term : base + term;
  end

  assign acc_o      = acc_d;
  assign wr_o.valid = vld_q && ctrl_q.last;
  assign wr_o.grp   = ctrl_q.grp;
  assign wr_o.comp  = ctrl_q.comp;

endmodule

`default_nettype wire

// ----- hw/rtl/rtnh_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module rtnh_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rtnh_pkg::DOT_W-1:0]    num_i,
  input  wire logic [rtnh_pkg::DOT_W-1:0]    den_i,
  output logic                               done_o,
  output logic [rtnh_pkg::DIST_W-1:0]        q_o
);
  import rtnh_pkg::*;

  localparam int CNT_W = $clog2(DIST_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [H_W-1:0]    h_q, den_q, h_sub;
  logic [DIST_W-2:0] low_q;
  logic [DIST_W-1:0] q_q;
  logic              ge;

  assign ge    = h_q >= den_q;
  assign h_sub = ge ? h_q - den_q : h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIST_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q   <= H_W'(num_i >> DIV_SH0);
      low_q <= {num_i[DIV_SH0-1:0], FRAC_W'(0)};
      den_q <= H_W'(den_i);
    end else if (busy_q) begin
      h_q   <= {h_sub[H_W-2:0], low_q[DIST_W-2]};
      low_q <= low_q << 1;
      q_q   <= {q_q[DIST_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ray_triangle_nearest_hit.sv -----
// Nearest ray / triangle hit finder, fixed-point Moller-Trumbore test.
// The user must set the ray (origin, direction) and the parallel threshold
// through the write port only while the block is idle; the block itself
// does not enforce this. Each triangle word passes through edge capture, the
// shared 34x34 multiplier for two cross and four dot products (two passes
// per dot term), sign and range tests, the bit-serial divider for the
// distance and an update of the running nearest hit. A rejected triangle
// skips the divider, an out-of-range identifier skips all arithmetic. On a
// word marked last the result goes to the output register and the running
// minimum clears; the next triangle may be taken while that result waits.
`default_nettype none

module ray_triangle_nearest_hit (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [rtnh_pkg::CFG_A_W-1:0]            cfg_idx_i,
  input  wire logic [rtnh_pkg::CFG_W-1:0]              cfg_data_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_a_x_i,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_a_y_i,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_a_z_i,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_b_x_i,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_b_y_i,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_b_z_i,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_c_x_i,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_c_y_i,
  input  wire logic signed [rtnh_pkg::COORD_WIDTH-1:0] vertex_c_z_i,
  input  wire logic [rtnh_pkg::SURF_W-1:0]             surface_number_i,
  input  wire logic [rtnh_pkg::TRI_W-1:0]              triangle_number_i,
  input  wire logic                                    last_triangle_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic                                         hit_found_o,
  output logic [rtnh_pkg::DIST_W-1:0]                  hit_distance_o,
  output logic [rtnh_pkg::SURF_W-1:0]                  hit_surface_o,
  output logic [rtnh_pkg::TRI_W-1:0]                   hit_triangle_o
);
  import rtnh_pkg::*;

  function automatic logic signed [EDGE_W-1:0] dif(input logic signed [COORD_WIDTH-1:0] p,
                                                   input logic signed [COORD_WIDTH-1:0] q);
    return EDGE_W'(p) - EDGE_W'(q);
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] x);
    logic [1:0] r;
    case (x)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  state_e state_q, state_d;

  // configuration
  logic signed [COORD_WIDTH-1:0] org_q [3];
  logic signed [COORD_WIDTH-1:0] dir_q [3];
  logic [EPS_W-1:0]              eps_q;

  // per-triangle datapath
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e2_q [3];
  logic signed [EDGE_W-1:0] tv_q [3];
  logic signed [WV_W-1:0]   pv_q [3];
  logic signed [WV_W-1:0]   qv_q [3];
  logic signed [DOT_W-1:0]  det_q, un_q, vn_q, tn_q, uv_sum;
  logic [SURF_W-1:0]        surf_q;
  logic [TRI_W-1:0]         tri_q;
  logic                     last_q;
  logic [DIST_W-1:0]        dist_q;

  // running nearest hit
  logic [DIST_W-1:0] best_dist_q;
  logic [SURF_W-1:0] best_surf_q;
  logic [TRI_W-1:0]  best_tri_q;
  logic              any_hit_q;

  // output register
  logic              out_valid_q, hit_found_q;
  logic [DIST_W-1:0] hit_dist_q;
  logic [SURF_W-1:0] hit_surf_q;
  logic [TRI_W-1:0]  hit_tri_q;

  // sequencer
  logic       issue_q;
  grp_e       grp_q;
  logic [1:0] comp_q;
  logic       half_q;
  logic       is_cross, in_fire, in_range, reject, div_start, div_done, emit, upd;
  logic [1:0] j1, j2, ia, ib;
  mac_ctrl_t  ctrl;
  mac_wr_t    wr;
  logic signed [OP_W-1:0]  op_a, op_b;
  logic signed [DOT_W-1:0] acc;
  logic [DIST_W-1:0]       div_q;

  assign in_ready_o = state_q == S_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = (32'(surface_number_i) < MAX_SURFACES) &&
                      (32'(triangle_number_i) < MAX_TRIANGLES);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= COORD_WIDTH'(1 << FRAC_W);
      eps_q    <= EPS_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: org_q[0] <= cfg_data_i;
        REG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        REG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        REG_DIR_X:    dir_q[0] <= cfg_data_i;
        REG_DIR_Y:    dir_q[1] <= cfg_data_i;
        REG_DIR_Z:    dir_q[2] <= cfg_data_i;
        REG_DET_EPS:  eps_q    <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    is_cross = (grp_q == G_PV) || (grp_q == G_QV);
    j1    = inc3(comp_q);
    j2    = inc3(j1);
    ia    = half_q ? j2 : j1;
    ib    = half_q ? j1 : j2;
    case (grp_q)
      G_PV: begin
        op_a = OP_W'(dir_q[ia]);
        op_b = OP_W'(e2_q[ib]);
      end
      G_QV: begin
        op_a = OP_W'(tv_q[ia]);
        op_b = OP_W'(e1_q[ib]);
      end
      G_DET: begin
        op_a = OP_W'(e1_q[comp_q]);
        op_b = half_q ? pv_q[comp_q][WV_W-1:LO_W] : {1'b0, pv_q[comp_q][LO_W-1:0]};
      end
      G_UN: begin
        op_a = OP_W'(tv_q[comp_q]);
        op_b = half_q ? pv_q[comp_q][WV_W-1:LO_W] : {1'b0, pv_q[comp_q][LO_W-1:0]};
      end
      G_VN: begin
        op_a = OP_W'(dir_q[comp_q]);
        op_b = half_q ? qv_q[comp_q][WV_W-1:LO_W] : {1'b0, qv_q[comp_q][LO_W-1:0]};
      end
      default: begin
        op_a = OP_W'(e2_q[comp_q]);
        op_b = half_q ? qv_q[comp_q][WV_W-1:LO_W] : {1'b0, qv_q[comp_q][LO_W-1:0]};
      end
    endcase
    ctrl.hi    = !is_cross && half_q;
    ctrl.sub   = is_cross && half_q;
    ctrl.first = !half_q && (is_cross || comp_q == 2'd0);
    ctrl.last  = half_q && (is_cross || comp_q == 2'd2);
    ctrl.grp   = grp_q;
    ctrl.comp  = comp_q;
  end

  rtnh_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue_q),
    .ctrl_i  (ctrl),
    .a_i     (op_a),
    .b_i     (op_b),
    .wr_o    (wr),
    .acc_o   (acc)
  );

  // issue sequence: cross pv, cross qv, then det, u, v, t dots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      grp_q   <= G_PV;
      comp_q  <= '0;
      half_q  <= 1'b0;
    end else if (in_fire) begin
      issue_q <= in_range;
      grp_q   <= G_PV;
      comp_q  <= '0;
      half_q  <= 1'b0;
    end else if (issue_q) begin
      half_q <= !half_q;
      if (half_q) begin
        if (comp_q == 2'd2) begin
          comp_q <= '0;
          if (grp_q == G_TN) begin
            issue_q <= 1'b0;
          end else begin
            grp_q <= grp_e'(grp_q + 3'd1);
          end
        end else begin
          comp_q <= comp_q + 2'd1;
        end
      end
    end
  end

  // range tests on sign-normalized values
  always_comb begin
    uv_sum = un_q + vn_q;
    reject = (det_q == '0) ||
             ($unsigned(det_q) < DOT_W'({eps_q, EPS_SH'(0)})) ||
             un_q[DOT_W-1] || (un_q > det_q) ||
             vn_q[DOT_W-1] || (uv_sum > det_q) ||
             tn_q[DOT_W-1] ||
             (DOT_W'(tn_q[DOT_W-1:SAT_SH]) >= $unsigned(det_q));
  end

  assign div_start = (state_q == S_CHECK) && !reject;

  rtnh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ($unsigned(tn_q)),
    .den_i   ($unsigned(det_q)),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // triangle datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e1_q[0] <= dif(vertex_b_x_i, vertex_a_x_i);
      e1_q[1] <= dif(vertex_b_y_i, vertex_a_y_i);
      e1_q[2] <= dif(vertex_b_z_i, vertex_a_z_i);
      e2_q[0] <= dif(vertex_c_x_i, vertex_a_x_i);
      e2_q[1] <= dif(vertex_c_y_i, vertex_a_y_i);
      e2_q[2] <= dif(vertex_c_z_i, vertex_a_z_i);
      tv_q[0] <= dif(org_q[0], vertex_a_x_i);
      tv_q[1] <= dif(org_q[1], vertex_a_y_i);
      tv_q[2] <= dif(org_q[2], vertex_a_z_i);
      surf_q  <= surface_number_i;
      tri_q   <= triangle_number_i;
      last_q  <= last_triangle_i;
      dist_q  <= DIST_MAX;
    end
    if (wr.valid) begin
      case (wr.grp)
        G_PV:    pv_q[wr.comp] <= acc[WV_W-1:0];
        G_QV:    qv_q[wr.comp] <= acc[WV_W-1:0];
        G_DET:   det_q <= acc;
        G_UN:    un_q  <= acc;
        G_VN:    vn_q  <= acc;
        default: tn_q  <= acc;
      endcase
    end
    if (state_q == S_NORM && det_q[DOT_W-1]) begin
      det_q <= -det_q;
      un_q  <= -un_q;
      vn_q  <= -vn_q;
      tn_q  <= -tn_q;
    end
    if (div_done) begin
      dist_q <= div_q;
    end
  end

  assign upd  = (state_q == S_DONE) && (dist_q < best_dist_q);
  assign emit = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // running nearest hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= DIST_MAX;
      best_surf_q <= '0;
      best_tri_q  <= '0;
      any_hit_q   <= 1'b0;
    end else if (emit) begin
      best_dist_q <= DIST_MAX;
      best_surf_q <= '0;
      best_tri_q  <= '0;
      any_hit_q   <= 1'b0;
    end else if (upd) begin
      best_dist_q <= dist_q;
      best_surf_q <= surf_q;
      best_tri_q  <= tri_q;
      any_hit_q   <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      hit_found_q <= any_hit_q;
      hit_dist_q  <= best_dist_q;
      hit_surf_q  <= best_surf_q;
      hit_tri_q   <= best_tri_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_found_o    = hit_found_q;
  assign hit_distance_o = hit_dist_q;
  assign hit_surface_o  = hit_surf_q;
  assign hit_triangle_o = hit_tri_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = in_range ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        if (wr.valid && wr.grp == G_TN) begin
          state_d = S_NORM;
        end
      end
      S_NORM:  state_d = S_CHECK;
      S_CHECK: state_d = reject ? S_DONE : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // a kept hit always has a real distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_hit_q == (best_dist_q != DIST_MAX))
    else $error("running hit flag disagrees with distance");

  // emitting a batch clears the running minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (best_dist_q == DIST_MAX) && !any_hit_q)
    else $error("running minimum not cleared on emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hit_found_q |-> hit_dist_q != DIST_MAX)
    else $error("reported hit with saturated distance");

endmodule

`default_nettype wire
